// File: sv/dpxu_pkg.sv
// Shared types and constants of the DPX sample unpacker.
`default_nettype none

package dpxu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int CARRY_W  = 8;
    localparam int MAX_CAND = 4;
    localparam int CNT_W    = 3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 22;
    localparam int MODE_W     = 3;
    localparam int SPR_W      = 22;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE            = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIG_ENDIAN      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_ROW = 2'd2;

    localparam logic [MODE_W-1:0] MODE_8B         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_10B_FILLED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_12B_FILLED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_16B        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_12B_PACKED = 3'd4;

    // Packed stream position: how many carried bits wait for the next word.
    typedef enum logic [1:0] {
        PH_ALIGNED = 2'd0,
        PH_CARRY8  = 2'd1,
        PH_CARRY4  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                               ok;
        logic [CNT_W-1:0]                   n;
        logic [MAX_CAND-1:0][SAMPLE_W-1:0]  cand;
        phase_t                             next_phase;
        logic [CARRY_W-1:0]                 next_carry;
    } dpxu_dec_t;

endpackage

`default_nettype wire

// File: sv/dpxu_decode.sv
// Word decoder: byte-order correction and sample extraction for all modes.
`default_nettype none

module dpxu_decode
    import dpxu_pkg::*;
(
    input  wire logic [WORD_W-1:0]  word,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic               big_endian,
    input  wire phase_t             phase,
    input  wire logic [CARRY_W-1:0] carry,
    output dpxu_dec_t               dec
);

    logic [WORD_W-1:0] t;

    assign t = big_endian ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};

    always_comb begin
        dec            = '0;
        dec.next_phase = PH_ALIGNED;
        unique case (mode)
            MODE_8B: begin
                dec.ok = 1'b1;
                dec.n  = 3'd4;
                if (big_endian) begin
                    dec.cand[0] = {8'h00, t[31:24]};
                    dec.cand[1] = {8'h00, t[23:16]};
                    dec.cand[2] = {8'h00, t[15:8]};
                    dec.cand[3] = {8'h00, t[7:0]};
                end else begin
                    dec.cand[0] = {8'h00, t[7:0]};
                    dec.cand[1] = {8'h00, t[15:8]};
                    dec.cand[2] = {8'h00, t[23:16]};
                    dec.cand[3] = {8'h00, t[31:24]};
                end
            end
            MODE_10B_FILLED: begin
                dec.ok      = 1'b1;
                dec.n       = 3'd3;
                dec.cand[0] = {t[31:22], 6'b0};
                dec.cand[1] = {t[21:12], 6'b0};
                dec.cand[2] = {t[11:2], 6'b0};
            end
            MODE_12B_FILLED: begin
                dec.ok = 1'b1;
                dec.n  = 3'd2;
                if (big_endian) begin
                    dec.cand[0] = {t[31:20], 4'b0};
                    dec.cand[1] = {t[15:4], 4'b0};
                end else begin
                    dec.cand[0] = {t[15:4], 4'b0};
                    dec.cand[1] = {t[31:20], 4'b0};
                end
            end
            MODE_16B: begin
                dec.ok = 1'b1;
                dec.n  = 3'd2;
                if (big_endian) begin
                    dec.cand[0] = t[31:16];
                    dec.cand[1] = t[15:0];
                end else begin
                    dec.cand[0] = t[15:0];
                    dec.cand[1] = t[31:16];
                end
            end
            MODE_12B_PACKED: begin
                dec.ok = 1'b1;
                unique case (phase)
                    PH_CARRY8: begin
                        dec.n          = 3'd3;
                        dec.cand[0]    = {t[3:0], carry, 4'b0};
                        dec.cand[1]    = {t[15:4], 4'b0};
                        dec.cand[2]    = {t[27:16], 4'b0};
                        dec.next_carry = {4'b0, t[31:28]};
                        dec.next_phase = PH_CARRY4;
                    end
                    PH_CARRY4: begin
                        dec.n          = 3'd3;
                        dec.cand[0]    = {t[7:0], carry[3:0], 4'b0};
                        dec.cand[1]    = {t[19:8], 4'b0};
                        dec.cand[2]    = {t[31:20], 4'b0};
                        dec.next_carry = '0;
                        dec.next_phase = PH_ALIGNED;
                    end
                    default: begin
                        dec.n          = 3'd2;
                        dec.cand[0]    = {t[11:0], 4'b0};
                        dec.cand[1]    = {t[23:12], 4'b0};
                        dec.next_carry = t[31:24];
                        dec.next_phase = PH_CARRY8;
                    end
                endcase
            end
            default: begin
                dec.ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/dpx_sample_unpacker.sv
// An accepted word waits in the input register, where it is decoded; its samples move into the
// output sample register once that is free. Output: one sample per cycle while m_ready is high;
// a word yields 4, 3 or 2 samples (fewer at a row end) from the single output sample register.
// An unused-mode word, with nothing to emit, is consumed from the input register without a result.
// Reset (aresetn low, synchronous) clears valids, row position, packed phase and carry, and sets
// mode 0, big_endian 1 and samples_per_row 1.
`default_nettype none

module dpx_sample_unpacker
    import dpxu_pkg::*;
#(
    parameter int MAX_ROW_SAMPLES = 2097152
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // word input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [WORD_W-1:0]     s_word,

    // sample output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [SAMPLE_W-1:0]        m_sample,
    output logic                       m_last_of_word,
    output logic                       m_end_of_row
);

    // Row length needs to hold MAX_ROW_SAMPLES itself; position only reaches MAX - 1.
    localparam int LEN_RAW = $clog2(MAX_ROW_SAMPLES + 1);
    localparam int LEN_W   = (LEN_RAW > CNT_W) ? LEN_RAW : CNT_W;
    localparam int POS_W   = (MAX_ROW_SAMPLES > 1) ? $clog2(MAX_ROW_SAMPLES) : 1;
    localparam int WIDE_W  = (LEN_W > SPR_W) ? LEN_W : SPR_W;
    localparam int IDX_W   = $clog2(MAX_CAND);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [MODE_W-1:0] mode_reg;
    logic              big_endian_reg;
    logic [SPR_W-1:0]  spr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_8B;
            big_endian_reg <= 1'b1;
            spr_reg        <= SPR_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MODE:            mode_reg       <= cfg_wdata[MODE_W-1:0];
                CFG_BIG_ENDIAN:      big_endian_reg <= cfg_wdata[0];
                CFG_SAMPLES_PER_ROW: spr_reg        <= cfg_wdata[SPR_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Effective row length: zero counts as one, saturate at the maximum.
    logic [WIDE_W-1:0] spr_wide;
    logic [LEN_W-1:0]  row_len;

    assign spr_wide = WIDE_W'(spr_reg);

    always_comb begin
        if (spr_wide == '0)
            row_len = LEN_W'(1);
        else if (spr_wide > WIDE_W'(MAX_ROW_SAMPLES))
            row_len = LEN_W'(MAX_ROW_SAMPLES);
        else
            row_len = LEN_W'(spr_wide);
    end

    // ---------------------------------------------------------------
    // Input register: holds one word while the output side drains
    // ---------------------------------------------------------------
    logic              in_valid_reg, in_valid_next;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_take;
    logic              buf_free;

    // ---------------------------------------------------------------
    // Stream state
    // ---------------------------------------------------------------
    logic [POS_W-1:0]   pos_reg, pos_next;
    phase_t             phase_reg, phase_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;

    dpxu_dec_t dec;

    dpxu_decode u_decode (
        .word       (in_word_reg),
        .mode       (mode_reg),
        .big_endian (big_endian_reg),
        .phase      (phase_reg),
        .carry      (carry_reg),
        .dec        (dec)
    );

    // Row accounting: samples left in the row decide how many of this
    // word's samples survive and whether the row closes on this word.
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] row_left;
    logic             row_end;
    logic [CNT_W-1:0] keep_cnt;

    assign pos_ext = LEN_W'(pos_reg);

    always_comb begin
        // position at or past the length: the next sample ends the row
        if (row_len > pos_ext)
            row_left = row_len - pos_ext;
        else
            row_left = LEN_W'(1);
        row_end  = (row_left <= LEN_W'(dec.n));
        keep_cnt = row_end ? row_left[CNT_W-1:0] : dec.n;
    end

    // ---------------------------------------------------------------
    // Output sample buffer: decoded samples of one word, sent, while m_ready is high, one a cycle
    // ---------------------------------------------------------------
    logic                              buf_valid_reg, buf_valid_next;
    logic [MAX_CAND-1:0][SAMPLE_W-1:0] buf_cand_reg, buf_cand_next;
    logic [CNT_W-1:0]                  buf_cnt_reg, buf_cnt_next;
    logic [IDX_W-1:0]                  buf_idx_reg, buf_idx_next;
    logic                              buf_eor_reg, buf_eor_next;
    logic                              buf_last;
    logic                              out_fire;

    assign buf_last = (CNT_W'(buf_idx_reg) + CNT_W'(1)) == buf_cnt_reg;
    assign out_fire = buf_valid_reg && m_ready;
    assign buf_free = !buf_valid_reg || (out_fire && buf_last);

    // A word of an unused mode yields nothing, so it never waits for the buffer.
    assign in_take = in_valid_reg && (!dec.ok || buf_free);
    assign s_ready = !in_valid_reg || in_take;

    always_comb begin
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (in_take)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // Advance stream state when a decodable word moves into the buffer.
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (in_take && dec.ok) begin
            pos_next = row_end ? '0 : POS_W'(pos_ext + LEN_W'(keep_cnt));
            if (mode_reg == MODE_12B_PACKED) begin
                phase_next = row_end ? PH_ALIGNED : dec.next_phase;
                carry_next = row_end ? '0 : dec.next_carry;
            end
        end
    end

    always_comb begin
        buf_valid_next = buf_valid_reg;
        buf_cand_next  = buf_cand_reg;
        buf_cnt_next   = buf_cnt_reg;
        buf_idx_next   = buf_idx_reg;
        buf_eor_next   = buf_eor_reg;
        if (in_take && dec.ok) begin
            // load the next word's samples
            buf_valid_next = 1'b1;
            buf_cand_next  = dec.cand;
            buf_cnt_next   = keep_cnt;
            buf_idx_next   = '0;
            buf_eor_next   = row_end;
        end else if (out_fire) begin
            if (buf_last)
                buf_valid_next = 1'b0;
            else
                buf_idx_next = buf_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            pos_reg       <= '0;
            phase_reg     <= PH_ALIGNED;
            carry_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            buf_valid_reg <= buf_valid_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            carry_reg     <= carry_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_word_reg <= s_word;
        buf_cand_reg <= buf_cand_next;
        buf_cnt_reg  <= buf_cnt_next;
        buf_idx_reg  <= buf_idx_next;
        buf_eor_reg  <= buf_eor_next;
    end

    assign m_valid        = buf_valid_reg;
    assign m_sample       = buf_cand_reg[buf_idx_reg];
    assign m_last_of_word = buf_last;
    assign m_end_of_row   = buf_last && buf_eor_reg;

`ifndef SYNTHESIS
    // The send index stays inside the loaded sample count.
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_valid_reg |-> (CNT_W'(buf_idx_reg) < buf_cnt_reg))
        else $error("sample index beyond loaded count");

    // A row always closes on the final sample of its word.
    a_eor_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_row) |-> m_last_of_word)
        else $error("end_of_row without last_of_word");

    // Only four carried bits survive into the second packed phase.
    a_carry4_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CARRY4) |-> (carry_reg[7:4] == 4'h0))
        else $error("stale high carry bits in four-bit carry phase");

    // After a row end the next word starts at position zero.
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && dec.ok && row_end) |=> (pos_reg == '0))
        else $error("row position not cleared at row end");
`endif

endmodule

`default_nettype wire
